>>> sv/dfwp_pkg.sv
package dfwp_pkg;

    // default channel count of one event
    localparam int CHANNELS_DEF = 320;

    // result field widths
    localparam int IDX_W = 10;
    localparam int VAL_W = 14;
    localparam int TS_W  = 64;
    localparam int CLK_W = 8;
    localparam int SYN_W = 4;

    // command queue between the parser and the result stage
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = 2;
    localparam int CMD_CW    = 3;

    // result kinds
    typedef enum logic [1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_SIZE       = 3'd1,
        ERR_COMPRESSED = 3'd2,
        ERR_HEADER     = 3'd3,
        ERR_FOOTER     = 3'd4
    } t_err;

    // fixed header and footer words
    localparam logic [31:0] HDR_MAGIC0   = 32'headebaba;
    localparam logic [31:0] HDR_MAGIC1   = 32'hd451d451;
    localparam logic [31:0] HDR_ADC0     = 32'h4ead0501;
    localparam logic [31:0] HDR_ADC1     = 32'h4ead1502;
    localparam logic [31:0] HDR_ADC2     = 32'h4ead2503;
    localparam logic [31:0] HDR_ADC3     = 32'h4ead3504;
    localparam logic [31:0] FTR_WORD0    = 32'hf007e501;
    localparam logic [31:0] FTR_WORD1    = 32'hf007e502;
    localparam logic [31:0] FTR_WORD2    = 32'hf007e503;
    localparam logic [15:0] FTR_STAT_LOW = 16'hfafe;
    localparam logic [31:0] FTR_TRAILER  = 32'hbacca000;

    // header offsets from the size word
    localparam logic [3:0] HOFS_MAGIC0 = 4'd1;
    localparam logic [3:0] HOFS_MAGIC1 = 4'd2;
    localparam logic [3:0] HOFS_COUNT  = 4'd3;
    localparam logic [3:0] HOFS_TS_LO  = 4'd4;
    localparam logic [3:0] HOFS_TS_HI  = 4'd5;
    localparam logic [3:0] HOFS_CHAN   = 4'd6;
    localparam logic [3:0] HOFS_ADC0   = 4'd7;
    localparam logic [3:0] HOFS_ADC1   = 4'd8;
    localparam logic [3:0] HOFS_ADC2   = 4'd9;
    localparam logic [3:0] HOFS_LAST   = 4'd10;

    // one queued command for the result stage
    typedef struct packed {
        t_kind             kind;
        t_err              err;
        logic [IDX_W-1:0]  idx_lo;
        logic [IDX_W-1:0]  idx_hi;
        logic [TS_W-1:0]   payload;
        logic [CLK_W-1:0]  clock_status;
        logic [SYN_W-1:0]  sync_nibble;
    } t_cmd;

    // expected value of a checked header word
    function automatic logic [31:0] header_expect(input logic [3:0] hofs,
                                                  input logic [31:0] chan_word);
        logic [31:0] exp_word;
        exp_word = HDR_ADC3;
        case (hofs)
            HOFS_MAGIC0: exp_word = HDR_MAGIC0;
            HOFS_MAGIC1: exp_word = HDR_MAGIC1;
            HOFS_CHAN:   exp_word = chan_word;
            HOFS_ADC0:   exp_word = HDR_ADC0;
            HOFS_ADC1:   exp_word = HDR_ADC1;
            HOFS_ADC2:   exp_word = HDR_ADC2;
            default:     exp_word = HDR_ADC3;
        endcase
        return exp_word;
    endfunction

endpackage

>>> sv/dfwp_front.sv
module dfwp_front #(
    parameter int CHANNELS = dfwp_pkg::CHANNELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_event_start,
    input  logic [31:0]   i_word,
    output logic          o_push,
    output dfwp_pkg::t_cmd o_cmd
);

    localparam int OFS_W = $clog2(CHANNELS + 17);
    localparam int Q_W   = $clog2((2 * CHANNELS - 1) / 10 + 1);

    localparam logic [OFS_W-1:0] OFS_HDR_LAST = OFS_W'(10);
    localparam logic [OFS_W-1:0] OFS_SMP_LAST = OFS_W'(10 + CHANNELS);
    localparam logic [OFS_W-1:0] OFS_FTR0     = OFS_W'(11 + CHANNELS);
    localparam logic [OFS_W-1:0] OFS_FTR1     = OFS_W'(12 + CHANNELS);
    localparam logic [OFS_W-1:0] OFS_FTR2     = OFS_W'(13 + CHANNELS);
    localparam logic [OFS_W-1:0] OFS_FTR3     = OFS_W'(14 + CHANNELS);

    localparam logic [30:0] SIZE_WORD = 31'(CHANNELS + 16);
    localparam logic [31:0] CHAN_WORD = 32'(CHANNELS + 8);

    logic                 r_in_event, n_in_event;
    logic [OFS_W-1:0]     r_ofs, n_ofs;
    logic [Q_W-1:0]       r_q, n_q;
    logic [2:0]           r_m, n_m;
    logic [31:0]          r_ts_lo, n_ts_lo;
    logic [31:0]          r_ts_hi, n_ts_hi;
    logic [dfwp_pkg::CLK_W-1:0] r_clk_stat, n_clk_stat;
    logic [dfwp_pkg::SYN_W-1:0] r_sync, n_sync;

    // word classification and command build
    always_comb begin
        logic             err_hit;
        dfwp_pkg::t_err   err_code;
        logic [dfwp_pkg::IDX_W-1:0] base;
        err_hit    = 1'b0;
        err_code   = dfwp_pkg::ERR_NONE;
        base       = {r_m, 7'b0} + dfwp_pkg::IDX_W'(r_q);
        n_in_event = r_in_event;
        n_ofs      = r_ofs;
        n_q        = r_q;
        n_m        = r_m;
        n_ts_lo    = r_ts_lo;
        n_ts_hi    = r_ts_hi;
        n_clk_stat = r_clk_stat;
        n_sync     = r_sync;
        o_push     = 1'b0;
        o_cmd      = '0;
        if (i_accept) begin
            if (i_event_start) begin
                n_in_event = 1'b1;
                n_ofs      = '0;
                n_q        = '0;
                n_m        = '0;
            end else if (r_in_event) begin
                n_ofs = r_ofs + 1'b1;
                if (r_ofs == '0) begin
                    // size word, compressed flag first
                    if (i_word[31]) begin
                        err_hit  = 1'b1;
                        err_code = dfwp_pkg::ERR_COMPRESSED;
                    end else if (i_word[30:0] != SIZE_WORD) begin
                        err_hit  = 1'b1;
                        err_code = dfwp_pkg::ERR_SIZE;
                    end
                end else if (r_ofs <= OFS_HDR_LAST) begin
                    // header words
                    if (r_ofs[3:0] == dfwp_pkg::HOFS_TS_LO) begin
                        n_ts_lo = i_word;
                    end else if (r_ofs[3:0] == dfwp_pkg::HOFS_TS_HI) begin
                        n_ts_hi = i_word;
                    end else if (r_ofs[3:0] != dfwp_pkg::HOFS_COUNT) begin
                        if (i_word != dfwp_pkg::header_expect(r_ofs[3:0], CHAN_WORD)) begin
                            err_hit  = 1'b1;
                            err_code = dfwp_pkg::ERR_HEADER;
                        end
                    end
                end else if (r_ofs <= OFS_SMP_LAST) begin
                    // channel word, two samples
                    o_push        = 1'b1;
                    o_cmd.kind    = dfwp_pkg::KIND_SAMPLE;
                    o_cmd.idx_lo  = base;
                    o_cmd.idx_hi  = base + dfwp_pkg::IDX_W'(64);
                    o_cmd.payload = {32'b0, i_word};
                    if (r_m == 3'd4) begin
                        n_m = '0;
                        n_q = r_q + 1'b1;
                    end else begin
                        n_m = r_m + 1'b1;
                    end
                end else if (r_ofs == OFS_FTR0) begin
                    err_hit  = (i_word != dfwp_pkg::FTR_WORD0);
                    err_code = dfwp_pkg::ERR_FOOTER;
                end else if (r_ofs == OFS_FTR1) begin
                    err_hit  = (i_word != dfwp_pkg::FTR_WORD1);
                    err_code = dfwp_pkg::ERR_FOOTER;
                end else if (r_ofs == OFS_FTR2) begin
                    err_hit  = (i_word != dfwp_pkg::FTR_WORD2);
                    err_code = dfwp_pkg::ERR_FOOTER;
                end else if (r_ofs == OFS_FTR3) begin
                    err_hit    = (i_word[15:0] != dfwp_pkg::FTR_STAT_LOW);
                    err_code   = dfwp_pkg::ERR_FOOTER;
                    n_clk_stat = i_word[31:24];
                    n_sync     = i_word[19:16];
                end else begin
                    // trailer closes the event
                    err_hit  = (i_word != dfwp_pkg::FTR_TRAILER);
                    err_code = dfwp_pkg::ERR_FOOTER;
                    if (!err_hit) begin
                        n_in_event         = 1'b0;
                        o_push             = 1'b1;
                        o_cmd.kind         = dfwp_pkg::KIND_SUMMARY;
                        o_cmd.payload      = {r_ts_hi, r_ts_lo};
                        o_cmd.clock_status = r_clk_stat;
                        o_cmd.sync_nibble  = r_sync;
                    end
                end
                // mismatch closes the event with one error item
                if (err_hit) begin
                    n_in_event = 1'b0;
                    o_push     = 1'b1;
                    o_cmd      = '0;
                    o_cmd.kind = dfwp_pkg::KIND_ERROR;
                    o_cmd.err  = err_code;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_event <= 1'b0;
            r_ofs      <= '0;
            r_q        <= '0;
            r_m        <= '0;
        end else begin
            r_in_event <= n_in_event;
            r_ofs      <= n_ofs;
            r_q        <= n_q;
            r_m        <= n_m;
        end
    end

    // captured timestamp and footer status
    always_ff @(posedge i_clk) begin
        r_ts_lo    <= n_ts_lo;
        r_ts_hi    <= n_ts_hi;
        r_clk_stat <= n_clk_stat;
        r_sync     <= n_sync;
    end

endmodule

>>> sv/dfwp_cmd_fifo.sv
module dfwp_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dfwp_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output dfwp_pkg::t_cmd o_head
);

    dfwp_pkg::t_cmd                  r_mem [dfwp_pkg::CMD_DEPTH];
    logic [dfwp_pkg::CMD_AW-1:0]     r_wr, n_wr;
    logic [dfwp_pkg::CMD_AW-1:0]     r_rd, n_rd;
    logic [dfwp_pkg::CMD_CW-1:0]     r_cnt, n_cnt;
    logic                            do_push, do_pop;

    assign o_full  = (r_cnt == dfwp_pkg::CMD_CW'(dfwp_pkg::CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // command storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

>>> sv/dfwp_back.sv
module dfwp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  dfwp_pkg::t_cmd              i_head,
    input  logic                        i_pop,
    output logic                        o_q_pop,
    output logic                        o_empty,
    output logic [1:0]                  o_kind,
    output logic [dfwp_pkg::IDX_W-1:0]  o_sample_index,
    output logic [dfwp_pkg::VAL_W-1:0]  o_sample_value,
    output logic [dfwp_pkg::TS_W-1:0]   o_timestamp,
    output logic [dfwp_pkg::CLK_W-1:0]  o_clock_status,
    output logic [dfwp_pkg::SYN_W-1:0]  o_sync_nibble,
    output logic [2:0]                  o_error_code,
    output logic                        o_last
);

    logic r_half, n_half;
    logic take;

    assign o_empty = i_q_empty;
    assign take    = i_pop && !i_q_empty;

    // a sample command gives its low half first, then its high half
    always_comb begin
        n_half  = r_half;
        o_q_pop = 1'b0;
        if (take) begin
            if (i_head.kind == dfwp_pkg::KIND_SAMPLE && !r_half) begin
                n_half = 1'b1;
            end else begin
                n_half  = 1'b0;
                o_q_pop = 1'b1;
            end
        end
    end

    // result fields from the head command
    always_comb begin
        o_kind         = i_head.kind;
        o_sample_index = '0;
        o_sample_value = '0;
        o_timestamp    = '0;
        o_clock_status = '0;
        o_sync_nibble  = '0;
        o_error_code   = '0;
        o_last         = 1'b1;
        case (i_head.kind)
            dfwp_pkg::KIND_SAMPLE: begin
                o_last = r_half;
                if (r_half) begin
                    o_sample_index = i_head.idx_hi;
                    o_sample_value = i_head.payload[31:18];
                end else begin
                    o_sample_index = i_head.idx_lo;
                    o_sample_value = i_head.payload[15:2];
                end
            end
            dfwp_pkg::KIND_SUMMARY: begin
                o_timestamp    = i_head.payload;
                o_clock_status = i_head.clock_status;
                o_sync_nibble  = i_head.sync_nibble;
            end
            default: begin
                o_error_code = i_head.err;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
        end else begin
            r_half <= n_half;
        end
    end

endmodule

>>> sv/detector_frame_word_parser.sv
// Detector readout event parser. Words of one event enter through a queue
// style port (push/full); an item with event_start high opens an event and
// the following words are the size word, ten header words, CHANNELS channel
// words and five footer words. Each channel word yields two 14-bit sample
// items with their de-interleaved index, the final footer word yields one
// summary item with the timestamp and clock status, and any mismatch yields
// one error item, after which words are dropped until the next event start.
// Results leave through a queue style port (empty/pop). The parser takes one
// word per cycle while the queue is not full and hands commands through a
// four-entry queue to the result stage, which sends one item per cycle while
// pop is high: a channel word yields two items on the single result port,
// while header, footer and ignored words yield one item or none. Commands
// are registered in the queue before they reach the result port.
module detector_frame_word_parser #(
    parameter int CHANNELS = dfwp_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_event_start,
    input  logic [31:0]                 i_word,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  o_kind,
    output logic [dfwp_pkg::IDX_W-1:0]  o_sample_index,
    output logic [dfwp_pkg::VAL_W-1:0]  o_sample_value,
    output logic [dfwp_pkg::TS_W-1:0]   o_timestamp,
    output logic [dfwp_pkg::CLK_W-1:0]  o_clock_status,
    output logic [dfwp_pkg::SYN_W-1:0]  o_sync_nibble,
    output logic [2:0]                  o_error_code,
    output logic                        o_last
);

    logic           accept;
    logic           cmd_push;
    dfwp_pkg::t_cmd cmd;
    logic           q_empty;
    logic           q_pop;
    dfwp_pkg::t_cmd q_head;

    assign accept = push && !full;

    // parser front end
    dfwp_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_event_start (i_event_start),
        .i_word        (i_word),
        .o_push        (cmd_push),
        .o_cmd         (cmd)
    );

    // command queue
    dfwp_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // result stage
    dfwp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_head         (q_head),
        .i_pop          (pop),
        .o_q_pop        (q_pop),
        .o_empty        (empty),
        .o_kind         (o_kind),
        .o_sample_index (o_sample_index),
        .o_sample_value (o_sample_value),
        .o_timestamp    (o_timestamp),
        .o_clock_status (o_clock_status),
        .o_sync_nibble  (o_sync_nibble),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

endmodule

>>> test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CHAN      = dfwp_pkg::CHANNELS_DEF;
    localparam logic [31:0] SIZE_OK   = 32'(CHAN + 16);
    localparam logic [31:0] CHAN_WORD = 32'(CHAN + 8);
    // offsets from the size word
    localparam int          DATA_OFS  = 11;
    localparam int          FTR_OFS   = DATA_OFS + CHAN;
    localparam int          LAST_OFS  = FTR_OFS + 4;
    localparam int          N_ITEMS   = 1250;
    localparam int          DIR_N     = 25;
    localparam int          LIMIT     = 600000;

    typedef struct {
        logic           start;
        logic [31:0]    word;
        logic           fixed_exp;
        dfwp_pkg::t_err fixed_err;
    } t_word_item;

    typedef struct {
        dfwp_pkg::t_kind              kind;
        logic [dfwp_pkg::IDX_W-1:0]   idx;
        logic [dfwp_pkg::VAL_W-1:0]   val;
        logic [dfwp_pkg::TS_W-1:0]    ts;
        logic [dfwp_pkg::CLK_W-1:0]   clk_stat;
        logic [dfwp_pkg::SYN_W-1:0]   sync;
        dfwp_pkg::t_err               err;
        logic                         last;
    } t_parse_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        i_event_start = 1'b0;
    logic [31:0] i_word = '0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  o_kind;
    logic [dfwp_pkg::IDX_W-1:0] o_sample_index;
    logic [dfwp_pkg::VAL_W-1:0] o_sample_value;
    logic [dfwp_pkg::TS_W-1:0]  o_timestamp;
    logic [dfwp_pkg::CLK_W-1:0] o_clock_status;
    logic [dfwp_pkg::SYN_W-1:0] o_sync_nibble;
    logic [2:0]  o_error_code;
    logic        o_last;

    // parser state as predicted
    logic        frame_open = 1'b0;
    int unsigned word_pos = 0;
    logic [31:0] stamp_lo = '0;
    logic [31:0] stamp_hi = '0;
    logic [15:0] footer_stat = '0;
    t_parse_res  step_res [2];

    t_word_item  word_items [$];
    t_parse_res  expected_results [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          cycles = 0;
    logic [15:0] stall_pat = 16'hffff;
    int          pat_age = 0;

    detector_frame_word_parser #(
        .CHANNELS(CHAN)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_event_start  (i_event_start),
        .i_word         (i_word),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_sample_index (o_sample_index),
        .o_sample_value (o_sample_value),
        .o_timestamp    (o_timestamp),
        .o_clock_status (o_clock_status),
        .o_sync_nibble  (o_sync_nibble),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_parse_res make_result(input dfwp_pkg::t_kind kind,
                                               input logic [dfwp_pkg::IDX_W-1:0] idx,
                                               input logic [dfwp_pkg::VAL_W-1:0] val,
                                               input logic [dfwp_pkg::TS_W-1:0] ts,
                                               input logic [dfwp_pkg::CLK_W-1:0] clk_stat,
                                               input logic [dfwp_pkg::SYN_W-1:0] sync,
                                               input dfwp_pkg::t_err err, input logic last);
        t_parse_res r;
        r.kind = kind;
        r.idx = idx;
        r.val = val;
        r.ts = ts;
        r.clk_stat = clk_stat;
        r.sync = sync;
        r.err = err;
        r.last = last;
        return r;
    endfunction

    // word a well-formed event carries at each offset (zero for the count and channel words)
    function automatic logic [31:0] good_word(input int ofs, input logic [31:0] ts_lo,
                                              input logic [31:0] ts_hi,
                                              input logic [15:0] stat);
        case (ofs)
            0:                     return SIZE_OK;
            dfwp_pkg::HOFS_MAGIC0: return dfwp_pkg::HDR_MAGIC0;
            dfwp_pkg::HOFS_MAGIC1: return dfwp_pkg::HDR_MAGIC1;
            dfwp_pkg::HOFS_TS_LO:  return ts_lo;
            dfwp_pkg::HOFS_TS_HI:  return ts_hi;
            dfwp_pkg::HOFS_CHAN:   return CHAN_WORD;
            dfwp_pkg::HOFS_ADC0:   return dfwp_pkg::HDR_ADC0;
            dfwp_pkg::HOFS_ADC1:   return dfwp_pkg::HDR_ADC1;
            dfwp_pkg::HOFS_ADC2:   return dfwp_pkg::HDR_ADC2;
            dfwp_pkg::HOFS_LAST:   return dfwp_pkg::HDR_ADC3;
            FTR_OFS:               return dfwp_pkg::FTR_WORD0;
            FTR_OFS + 1:           return dfwp_pkg::FTR_WORD1;
            FTR_OFS + 2:           return dfwp_pkg::FTR_WORD2;
            FTR_OFS + 3:           return {stat, dfwp_pkg::FTR_STAT_LOW};
            LAST_OFS:              return dfwp_pkg::FTR_TRAILER;
            default:               return '0;
        endcase
    endfunction

    function automatic logic [dfwp_pkg::IDX_W-1:0] sample_slot(input int unsigned j);
        return dfwp_pkg::IDX_W'(64 * (j % 10) + j / 10);
    endfunction

    function automatic int close_with_error(input dfwp_pkg::t_err code);
        frame_open = 1'b0;
        step_res[0] = make_result(dfwp_pkg::KIND_ERROR, '0, '0, '0, '0, '0, code, 1'b1);
        return 1;
    endfunction

    // advance the parser by one word, results land in step_res
    function automatic int parse_word(input logic start, input logic [31:0] w);
        int unsigned ofs;
        int unsigned j;
        if (start) begin
            frame_open = 1'b1;
            word_pos = 1;
            return 0;
        end
        if (!frame_open)
            return 0;
        ofs = word_pos - 1;
        word_pos++;
        if (ofs == 0) begin
            if (w[31])
                return close_with_error(dfwp_pkg::ERR_COMPRESSED);
            if (w[30:0] != SIZE_OK[30:0])
                return close_with_error(dfwp_pkg::ERR_SIZE);
            return 0;
        end
        if (ofs < DATA_OFS) begin
            case (ofs)
                dfwp_pkg::HOFS_COUNT: return 0;
                dfwp_pkg::HOFS_TS_LO: begin
                    stamp_lo = w;
                    return 0;
                end
                dfwp_pkg::HOFS_TS_HI: begin
                    stamp_hi = w;
                    return 0;
                end
                default: begin
                    if (w != good_word(ofs, '0, '0, '0))
                        return close_with_error(dfwp_pkg::ERR_HEADER);
                    return 0;
                end
            endcase
        end
        if (ofs < FTR_OFS) begin
            j = 2 * (ofs - DATA_OFS);
            step_res[0] = make_result(dfwp_pkg::KIND_SAMPLE, sample_slot(j), w[15:2],
                                      '0, '0, '0, dfwp_pkg::ERR_NONE, 1'b0);
            step_res[1] = make_result(dfwp_pkg::KIND_SAMPLE, sample_slot(j + 1), w[31:18],
                                      '0, '0, '0, dfwp_pkg::ERR_NONE, 1'b1);
            return 2;
        end
        if (ofs == FTR_OFS + 3) begin
            if (w[15:0] != dfwp_pkg::FTR_STAT_LOW)
                return close_with_error(dfwp_pkg::ERR_FOOTER);
            footer_stat = w[31:16];
            return 0;
        end
        if (w != good_word(ofs, '0, '0, '0))
            return close_with_error(dfwp_pkg::ERR_FOOTER);
        if (ofs == LAST_OFS) begin
            frame_open = 1'b0;
            step_res[0] = make_result(dfwp_pkg::KIND_SUMMARY, '0, '0, {stamp_hi, stamp_lo},
                                      footer_stat[15:8], footer_stat[3:0],
                                      dfwp_pkg::ERR_NONE, 1'b1);
            return 1;
        end
        return 0;
    endfunction

    // queue what an accepted item should produce
    task automatic predict_item(input t_word_item it);
        int n;
        n = parse_word(it.start, it.word);
        if (it.fixed_exp) begin
            if (it.fixed_err != dfwp_pkg::ERR_NONE)
                expected_results.push_back(make_result(dfwp_pkg::KIND_ERROR, '0, '0, '0,
                                                       '0, '0, it.fixed_err, 1'b1));
        end else begin
            for (int k = 0; k < n; k++)
                expected_results.push_back(step_res[k]);
        end
    endtask

    task automatic add_item(input logic start, input logic [31:0] w);
        word_items.push_back('{start, w, 1'b0, dfwp_pkg::ERR_NONE});
    endtask

    task automatic build_stimulus();
        t_word_item  directed_rows [DIR_N];
        int          pick;
        int          cut;
        int          bad_ofs;
        int          k;
        logic [31:0] tlo;
        logic [31:0] thi;
        logic [31:0] w;
        logic [31:0] mask;
        logic [15:0] stat;
        directed_rows = '{
            '{1'b0, 32'hffff_ffff, 1'b1, dfwp_pkg::ERR_NONE},  // idle word, no event open
            '{1'b1, 32'h0000_0000, 1'b1, dfwp_pkg::ERR_NONE},
            '{1'b0, 32'hffff_ffff, 1'b1, dfwp_pkg::ERR_COMPRESSED},
            '{1'b0, 32'h0000_0000, 1'b1, dfwp_pkg::ERR_NONE},  // dropped after an error
            '{1'b1, 32'hffff_ffff, 1'b1, dfwp_pkg::ERR_NONE},
            '{1'b0, 32'h0000_0000, 1'b1, dfwp_pkg::ERR_SIZE},
            '{1'b1, 32'h0000_0000, 1'b1, dfwp_pkg::ERR_NONE},
            '{1'b0, 32'h7fff_ffff, 1'b1, dfwp_pkg::ERR_SIZE},
            '{1'b1, 32'h0000_0000, 1'b1, dfwp_pkg::ERR_NONE},
            // flag set on a correct size
            '{1'b0, SIZE_OK | 32'h8000_0000, 1'b1, dfwp_pkg::ERR_COMPRESSED},
            '{1'b1, 32'h0000_0000, 1'b1, dfwp_pkg::ERR_NONE},
            '{1'b0, SIZE_OK, 1'b1, dfwp_pkg::ERR_NONE},
            '{1'b0, 32'h0000_0000, 1'b1, dfwp_pkg::ERR_HEADER},
            '{1'b1, 32'h0000_0000, 1'b0, dfwp_pkg::ERR_NONE},
            '{1'b0, SIZE_OK, 1'b0, dfwp_pkg::ERR_NONE},
            '{1'b0, dfwp_pkg::HDR_MAGIC0, 1'b0, dfwp_pkg::ERR_NONE},
            '{1'b1, 32'h1234_5678, 1'b1, dfwp_pkg::ERR_NONE},  // restart inside the header
            '{1'b0, SIZE_OK, 1'b0, dfwp_pkg::ERR_NONE},
            '{1'b0, dfwp_pkg::HDR_MAGIC0, 1'b0, dfwp_pkg::ERR_NONE},
            '{1'b0, dfwp_pkg::HDR_MAGIC1, 1'b0, dfwp_pkg::ERR_NONE},
            '{1'b0, 32'hffff_ffff, 1'b0, dfwp_pkg::ERR_NONE},
            '{1'b0, 32'hffff_ffff, 1'b0, dfwp_pkg::ERR_NONE},
            '{1'b0, 32'h0000_0000, 1'b0, dfwp_pkg::ERR_NONE},
            '{1'b0, CHAN_WORD, 1'b0, dfwp_pkg::ERR_NONE},
            '{1'b0, dfwp_pkg::HDR_ADC1, 1'b1, dfwp_pkg::ERR_HEADER}  // adc words out of order
        };
        foreach (directed_rows[i])
            word_items.push_back(directed_rows[i]);

        while (word_items.size() < N_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // noise, mostly ignored outside an event
                repeat ($urandom_range(1, 6))
                    add_item($urandom_range(0, 7) == 0, $urandom);
            end else begin
                tlo = $urandom;
                thi = $urandom;
                stat = 16'($urandom);
                bad_ofs = -1;
                cut = LAST_OFS;
                if (pick < 40) begin
                    // corrupt one checked word: size, header or footer
                    k = $urandom_range(0, 12);
                    bad_ofs = (k < 3) ? k : (k < 8) ? k + 3 : FTR_OFS + k - 8;
                end else if (pick < 52) begin
                    cut = $urandom_range(0, LAST_OFS - 1);
                end
                add_item(1'b1, $urandom);
                for (int ofs = 0; ofs <= cut; ofs++) begin
                    if (ofs == dfwp_pkg::HOFS_COUNT) begin
                        w = $urandom;
                    end else if (ofs >= DATA_OFS && ofs < FTR_OFS) begin
                        case ($urandom_range(0, 7))
                            0:       w = '0;
                            1:       w = '1;
                            default: w = $urandom;
                        endcase
                    end else begin
                        w = good_word(ofs, tlo, thi, stat);
                    end
                    if (ofs == bad_ofs) begin
                        mask = $urandom_range(0, 1) ? (32'h1 << $urandom_range(0, 31))
                                                    : $urandom;
                        if (ofs == FTR_OFS + 3)
                            mask[31:16] = '0;
                        if (mask == '0)
                            mask = 32'h1;
                        w = w ^ mask;
                    end
                    add_item(1'b0, w);
                    if (ofs == bad_ofs || word_items.size() >= N_ITEMS)
                        break;
                end
                if (bad_ofs >= 0)
                    repeat ($urandom_range(0, 3))
                        add_item(1'b0, $urandom);
            end
        end
    endtask

    // sender: bursts and gaps, drains fully at the hold points
    initial begin
        int sent;
        int burst_left;
        int gap_left;
        int hold_a;
        int hold_b;
        build_stimulus();
        sent = 0;
        burst_left = 1;
        gap_left = 0;
        hold_a = DIR_N;
        hold_b = word_items.size() / 2;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (sent < word_items.size()) begin
            @(posedge i_clk);
            if (push && !full) begin
                predict_item(word_items[sent]);
                sent++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (sent < word_items.size() && gap_left == 0 &&
                !((sent == hold_a || sent == hold_b) && expected_results.size() != 0)) begin
                push <= 1'b1;
                i_event_start <= word_items[sent].start;
                i_word <= word_items[sent].word;
            end else begin
                push <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
        end
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (!empty)
            report_mismatch("result waiting with nothing predicted");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // receiver: rotating stall pattern, reloaded now and then
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pat_age == 0) begin
                pat_age = $urandom_range(20, 80);
                case ($urandom_range(0, 3))
                    0:       stall_pat = 16'hffff;
                    1:       stall_pat = 16'($urandom);
                    2:       stall_pat = 16'($urandom & $urandom);
                    default: stall_pat = 16'($urandom | $urandom);
                endcase
            end
            pat_age--;
            pop <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns, result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
    endtask

    // compare each popped item with the oldest prediction
    always @(posedge i_clk) begin
        t_parse_res want;
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result popped with nothing predicted");
            end else begin
                want = expected_results.pop_front();
                check_field("kind", 64'(o_kind), 64'(want.kind));
                check_field("sample_index", 64'(o_sample_index), 64'(want.idx));
                check_field("sample_value", 64'(o_sample_value), 64'(want.val));
                check_field("timestamp", o_timestamp, want.ts);
                check_field("clock_status", 64'(o_clock_status), 64'(want.clk_stat));
                check_field("sync_nibble", 64'(o_sync_nibble), 64'(want.sync));
                check_field("error_code", 64'(o_error_code), 64'(want.err));
                check_field("last", 64'(o_last), 64'(want.last));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
